// ----- sv/wsrt_pkg.sv -----
`default_nettype none
package wsrt_pkg;

    localparam int MAX_SITES_DEF  = 64;
    localparam int INDEX_BITS_DEF = 24;

    localparam int SITE_IDX_W = 24;
    localparam int RATE_W     = 32;
    localparam int MULT_W     = 16;
    localparam int PROD_W     = RATE_W + MULT_W;
    localparam int SUM_W      = 54;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_REMOVE,
        ACT_REBUILD,
        ACT_NONE
    } action_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_MUL,
        S_ADD_ACC,
        S_SEARCH,
        S_REM_SUB,
        S_REM_MOVE,
        S_RB_RD,
        S_RB_MUL,
        S_RB_ACC,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    latch_in;       // capture the input transaction, restart the walk
        logic    rd_issue;       // read entry at walk pointer and advance it
        logic    rd_tail;        // read the last entry
        logic    mul_load;       // register rate * multiplicity
        logic    mul_from_input; // multiplier operands from the latched input
        logic    found_load;     // remember the matching slot
        logic    ram_wr_add;     // append the latched site
        logic    ram_wr_move;    // move the tail entry into the found slot
        logic    total_add;
        logic    total_sub;
        logic    count_inc;
        logic    count_dec;
        logic    set_code;
        status_t code;
        logic    load_resp;      // single result with last set
        logic    load_entry;     // one cumulative entry of a rebuild
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic cmp_vld;
        logic walk_done;
        logic out_free;
    } sts_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PROD_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/weighted_site_rate_table.sv -----
// Weighted site rate table.
// Input stream: s_axis_tuser carries the action (add, remove, rebuild);
// s_axis_tdata carries site index, Q16.16 rate and Q8.8 multiplicity.
// Output stream: one transaction per add, remove or unused action, and one
// per stored entry on rebuild (a single one when the table is empty);
// m_axis_tlast marks the final transaction of each input transaction.
// m_axis_tuser carries the status code; tdata carries the running total,
// the entry position, its cumulative weighted rate and the site count.
// Steps per input transaction, run by the FSM over the site RAM (one write
// port, one registered read port) and the registered multiplier:
//   add                  append and multiply, then accumulate
//   remove               linear search (one entry a cycle), subtract, move the tail
//   rebuild              read, multiply, accumulate for each entry
// Reset empties the table and zeroes the total; no clearing pass is needed.
// A new input transaction is taken while the last result still waits; when
// the receiver stalls, the block holds the pending result and waits.
`default_nettype none
module weighted_site_rate_table #(
    parameter int MAX_SITES  = wsrt_pkg::MAX_SITES_DEF,
    parameter int INDEX_BITS = wsrt_pkg::INDEX_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // site_index[23:0], rate[55:24], multiplicity[71:56]
    input  wire logic [1:0]   s_axis_tuser,  // action[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // total_rate[53:0], position[59:54],
                                             // cumulative_rate[113:60], count[120:114], zero
    output logic [1:0]        m_axis_tuser,  // status[1:0]
    output logic              m_axis_tlast
);
    import wsrt_pkg::*;

    cmd_t                 cmd;
    sts_t                 sts;
    status_t              out_status;
    logic [SUM_W-1:0]     out_total_rate;
    logic [POS_W-1:0]     out_position;
    logic [SUM_W-1:0]     out_cumulative_rate;
    logic [COUNT_W-1:0]   out_count;

    wsrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .action   (action_t'(s_axis_tuser)),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    wsrt_dp #(
        .MAX_SITES  (MAX_SITES),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .site_index          (s_axis_tdata[23:0]),
        .rate                (s_axis_tdata[55:24]),
        .multiplicity        (s_axis_tdata[71:56]),
        .cmd                 (cmd),
        .sts                 (sts),
        .out_ready           (m_axis_tready),
        .out_valid           (m_axis_tvalid),
        .out_status          (out_status),
        .out_total_rate      (out_total_rate),
        .out_position        (out_position),
        .out_cumulative_rate (out_cumulative_rate),
        .out_count           (out_count),
        .out_last            (m_axis_tlast)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {7'd0, out_count, out_cumulative_rate, out_position, out_total_rate};

endmodule
`default_nettype wire

// ----- sv/wsrt_ram.sv -----
`default_nettype none
module wsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/wsrt_ctrl.sv -----
`default_nettype none
module wsrt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire wsrt_pkg::action_t action,
    input  wire wsrt_pkg::sts_t    sts,
    output logic                   in_ready,
    output wsrt_pkg::cmd_t         cmd
);
    import wsrt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_ADD:     state_next = sts.full ? S_RESP : S_ADD_MUL;
                        ACT_REMOVE:  state_next = sts.empty ? S_RESP : S_SEARCH;
                        ACT_REBUILD: state_next = sts.empty ? S_RESP : S_RB_RD;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_ADD_MUL:  state_next = S_ADD_ACC;
            S_ADD_ACC:  state_next = S_RESP;
            S_SEARCH:
            begin
                if (sts.hit)
                begin
                    state_next = S_REM_SUB;
                end
                else if (sts.walk_done && !sts.cmp_vld)
                begin
                    state_next = S_RESP;
                end
            end
            S_REM_SUB:  state_next = S_REM_MOVE;
            S_REM_MOVE: state_next = S_RESP;
            S_RB_RD:    state_next = S_RB_MUL;
            S_RB_MUL:   state_next = S_RB_ACC;
            S_RB_ACC:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.walk_done ? S_IDLE : S_RB_RD;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_in = 1'b1;
                    cmd.set_code = 1'b1;
                    if (action == ACT_ADD && sts.full)
                    begin
                        cmd.code = ST_FULL;
                    end
                    else if (action == ACT_REMOVE && sts.empty)
                    begin
                        cmd.code = ST_NOT_FOUND;
                    end
                end
            end
            S_ADD_MUL:
            begin
                cmd.mul_load       = 1'b1;
                cmd.mul_from_input = 1'b1;
                cmd.ram_wr_add     = 1'b1;
            end
            S_ADD_ACC:
            begin
                cmd.total_add = 1'b1;
                cmd.count_inc = 1'b1;
            end
            S_SEARCH:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.hit)
                begin
                    cmd.mul_load   = 1'b1;
                    cmd.found_load = 1'b1;
                end
                else if (sts.walk_done && !sts.cmp_vld)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOT_FOUND;
                end
            end
            S_REM_SUB:
            begin
                cmd.total_sub = 1'b1;
                cmd.rd_tail   = 1'b1;
            end
            S_REM_MOVE:
            begin
                cmd.ram_wr_move = 1'b1;
                cmd.count_dec   = 1'b1;
            end
            S_RB_RD:    cmd.rd_issue = 1'b1;
            S_RB_MUL:   cmd.mul_load = 1'b1;
            S_RB_ACC:   cmd.load_entry = sts.out_free;
            S_RESP:     cmd.load_resp = sts.out_free;
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/wsrt_dp.sv -----
`default_nettype none
module wsrt_dp #(
    parameter int MAX_SITES  = 64,
    parameter int INDEX_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [wsrt_pkg::SITE_IDX_W-1:0]       site_index,
    input  wire logic [wsrt_pkg::RATE_W-1:0]           rate,
    input  wire logic [wsrt_pkg::MULT_W-1:0]           multiplicity,
    input  wire wsrt_pkg::cmd_t                        cmd,
    output wsrt_pkg::sts_t                             sts,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output wsrt_pkg::status_t                          out_status,
    output logic [wsrt_pkg::SUM_W-1:0]                 out_total_rate,
    output logic [wsrt_pkg::POS_W-1:0]                 out_position,
    output logic [wsrt_pkg::SUM_W-1:0]                 out_cumulative_rate,
    output logic [wsrt_pkg::COUNT_W-1:0]               out_count,
    output logic                                       out_last
);
    import wsrt_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_SITES);
    localparam int CNT_W   = $clog2(MAX_SITES + 1);
    localparam int ENTRY_W = INDEX_BITS + RATE_W + MULT_W;

    logic [INDEX_BITS-1:0] idx_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [MULT_W-1:0]     mult_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  cmp_vld_reg;
    logic [ADDR_W-1:0]     cmp_addr_reg;
    logic [ADDR_W-1:0]     found_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SUM_W-1:0]      prefix_reg, prefix_next;
    status_t               code_reg;

    logic                  issue;
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr, tail_addr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
    logic [INDEX_BITS-1:0] rd_idx;
    logic [RATE_W-1:0]     rd_rate, mul_a;
    logic [MULT_W-1:0]     rd_mult, mul_b;
    logic                  out_free;

    assign issue     = cmd.rd_issue && (ptr_reg < count_reg);
    assign tail_addr = ADDR_W'(count_reg - 1'b1);
    assign ram_re    = issue || cmd.rd_tail;
    assign ram_raddr = cmd.rd_tail ? tail_addr : ptr_reg[ADDR_W-1:0];
    assign ram_we    = cmd.ram_wr_add || cmd.ram_wr_move;
    assign ram_waddr = cmd.ram_wr_move ? found_reg : count_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.ram_wr_move ? ram_rdata : {idx_reg, rate_reg, mult_reg};

    wsrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SITES)
    ) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_idx, rd_rate, rd_mult} = ram_rdata;
    assign mul_a = cmd.mul_from_input ? rate_reg : rd_rate;
    assign mul_b = cmd.mul_from_input ? mult_reg : rd_mult;

    assign out_free = !out_valid || out_ready;

    assign sts.full      = (count_reg == CNT_W'(MAX_SITES));
    assign sts.empty     = (count_reg == '0);
    assign sts.hit       = cmp_vld_reg && (rd_idx == idx_reg);
    assign sts.cmp_vld   = cmp_vld_reg;
    assign sts.walk_done = (ptr_reg == count_reg);
    assign sts.out_free  = out_free;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end

        total_next = total_reg;
        if (cmd.total_add)
        begin
            total_next = sat_add(total_reg, prod_reg);
        end
        else if (cmd.total_sub)
        begin
            // clamp at zero, reachable only after saturation
            total_next = (SUM_W'(prod_reg) > total_reg) ? '0 : total_reg - SUM_W'(prod_reg);
        end

        ptr_next = ptr_reg;
        if (cmd.latch_in)
        begin
            ptr_next = '0;
        end
        else if (issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        prefix_next = sat_add(prefix_reg, prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            out_valid   <= 1'b0;
            code_reg    <= ST_OK;
        end
        else
        begin
            count_reg   <= count_next;
            total_reg   <= total_next;
            ptr_reg     <= ptr_next;
            cmp_vld_reg <= issue;
            if (cmd.set_code)
            begin
                code_reg <= cmd.code;
            end
            if (cmd.load_resp || cmd.load_entry)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            idx_reg    <= INDEX_BITS'(site_index);
            rate_reg   <= rate;
            mult_reg   <= multiplicity;
            prefix_reg <= '0;
        end
        else if (cmd.load_entry)
        begin
            prefix_reg <= prefix_next;
        end
        if (issue)
        begin
            cmp_addr_reg <= ptr_reg[ADDR_W-1:0];
        end
        if (cmd.found_load)
        begin
            found_reg <= cmp_addr_reg;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.load_resp)
        begin
            out_status          <= code_reg;
            out_total_rate      <= total_reg;
            out_position        <= '0;
            out_cumulative_rate <= '0;
            out_count           <= COUNT_W'(count_reg);
            out_last            <= 1'b1;
        end
        else if (cmd.load_entry)
        begin
            out_status          <= ST_OK;
            out_total_rate      <= total_reg;
            out_position        <= POS_W'(cmp_addr_reg);
            out_cumulative_rate <= prefix_next;
            out_count           <= COUNT_W'(count_reg);
            out_last            <= (ptr_reg == count_reg);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SITES))
        else $error("site count beyond table depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_resp || cmd.load_entry) |-> out_free)
        else $error("result register overwritten while held");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("add did not advance the site count");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_wr_move |-> (count_reg != '0 && found_reg <= tail_addr))
        else $error("swap-remove on empty table or past the tail");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

import wsrt_pkg::*;

typedef struct {
    status_t            status;
    logic [SUM_W-1:0]   total;
    logic [POS_W-1:0]   position;
    logic [SUM_W-1:0]   cumulative;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic [6:0]         pad;
} table_reply_t;

class rate_table_scoreboard;
    logic [SITE_IDX_W-1:0] ids[MAX_SITES_DEF];
    logic [RATE_W-1:0]     rates[MAX_SITES_DEF];
    logic [MULT_W-1:0]     mults[MAX_SITES_DEF];
    int                    sites;
    logic [SUM_W-1:0]      total;
    table_reply_t          expected_replies[$];
    int                    errors;

    function new();
        sites  = 0;
        total  = '0;
        errors = 0;
    endfunction

    function logic [SUM_W-1:0] clamp_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function logic [SUM_W-1:0] weight_at(int slot);
        return SUM_W'(rates[slot]) * SUM_W'(mults[slot]);
    endfunction

    function void expect_reply(status_t st, int pos, logic [SUM_W-1:0] cum, bit is_last);
        table_reply_t r;
        r.status     = st;
        r.total      = total;
        r.position   = POS_W'(pos);
        r.cumulative = cum;
        r.count      = COUNT_W'(sites);
        r.last       = is_last;
        r.pad        = '0;
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Advance the table by one accepted input transaction and queue its results.
    function void note_input(action_t act, logic [SITE_IDX_W-1:0] id,
                             logic [RATE_W-1:0] rate, logic [MULT_W-1:0] mult);
        int               hit;
        int               i;
        logic [SUM_W-1:0] w;
        logic [SUM_W-1:0] prefix;
        case (act)
            ACT_ADD:
            begin
                if (sites >= MAX_SITES_DEF)
                    expect_reply(ST_FULL, 0, '0, 1'b1);
                else
                begin
                    ids[sites]   = id;
                    rates[sites] = rate;
                    mults[sites] = mult;
                    total = clamp_sum(total, weight_at(sites));
                    sites++;
                    expect_reply(ST_OK, 0, '0, 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < sites; i++)
                    if (hit < 0 && ids[i] == id)
                        hit = i;
                if (hit < 0)
                    expect_reply(ST_NOT_FOUND, 0, '0, 1'b1);
                else
                begin
                    w = weight_at(hit);
                    // only reachable after the total has saturated
                    total = (w > total) ? '0 : total - w;
                    ids[hit]   = ids[sites-1];
                    rates[hit] = rates[sites-1];
                    mults[hit] = mults[sites-1];
                    sites--;
                    expect_reply(ST_OK, 0, '0, 1'b1);
                end
            end
            ACT_REBUILD:
            begin
                if (sites == 0)
                    expect_reply(ST_OK, 0, '0, 1'b1);
                prefix = '0;
                for (i = 0; i < sites; i++)
                begin
                    prefix = clamp_sum(prefix, weight_at(i));
                    expect_reply(ST_OK, i, prefix, i == sites - 1);
                end
            end
            default:
                expect_reply(ST_OK, 0, '0, 1'b1);
        endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_reply(table_reply_t got);
        table_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got status %0d total %0h pos %0d",
                     $time, got.status, got.total, got.position);
            errors++;
            return;
        end
        want = expected_replies.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("total_rate", want.total, got.total);
        compare_field("position", want.position, got.position);
        compare_field("cumulative_rate", want.cumulative, got.cumulative);
        compare_field("count", want.count, got.count);
        compare_field("last", want.last, got.last);
        compare_field("tdata padding", want.pad, got.pad);
    endfunction
endclass

module testbench;
    localparam int TABLE_DEPTH = MAX_SITES_DEF;
    localparam int GAP_MAX     = 19;
    localparam int LONG_HOLD   = 600;
    localparam int TAIL_CYCLES = 250;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 260;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // site_index[23:0], rate[55:24], multiplicity[71:56]
    logic [1:0]   s_axis_tuser;   // action[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // total_rate, position, cumulative_rate, count, zero
    logic [1:0]   m_axis_tuser;   // status[1:0]
    logic         m_axis_tlast;

    rate_table_scoreboard sb = new();

    int tx_max_gap    = GAP_MAX;
    int rx_max_gap    = GAP_MAX;
    bit hold_off_req  = 1'b0;
    int items_sent    = 0;
    int cycle_count   = 0;

    always #4 clk = ~clk;

    weighted_site_rate_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [SITE_IDX_W-1:0] pick_site_id();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SITE_IDX_W'($urandom_range(15, 0));  // force duplicates
            default: return SITE_IDX_W'($urandom);
        endcase
    endfunction

    function automatic logic [SITE_IDX_W-1:0] existing_site_id();
        return sb.ids[$urandom_range(sb.sites - 1, 0)];
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            2:       return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MULT_W-1:0] pick_mult();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            2:       return 16'h0100;
            default: return MULT_W'($urandom);
        endcase
    endfunction

    task automatic send_item(action_t act, logic [SITE_IDX_W-1:0] id,
                             logic [RATE_W-1:0] rate, logic [MULT_W-1:0] mult);
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {mult, rate, id};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(act, id, rate, mult);
        items_sent++;
    endtask

    // Hold the input side until every queued result has been received.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_replies.size() != 0);
    endtask

    task automatic remove_some_site();
        if (sb.sites > 0 && $urandom_range(7, 0) != 0)
            send_item(ACT_REMOVE, existing_site_id(), $urandom, MULT_W'($urandom));
        else
            send_item(ACT_REMOVE, pick_site_id(), $urandom, MULT_W'($urandom));
    endtask

    task automatic churn_item();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 45)
            send_item(ACT_ADD, pick_site_id(), pick_rate(), pick_mult());
        else if (roll < 78)
            remove_some_site();
        else if (roll < 95)
            send_item(ACT_REBUILD, pick_site_id(), $urandom, MULT_W'($urandom));
        else
            send_item(ACT_NONE, pick_site_id(), $urandom, MULT_W'($urandom));
    endtask

    initial
    begin : result_sink
        int           stall;
        table_reply_t got;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = $urandom_range(rx_max_gap, 0);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.status     = status_t'(m_axis_tuser);
            got.total      = m_axis_tdata[53:0];
            got.position   = m_axis_tdata[59:54];
            got.cumulative = m_axis_tdata[113:60];
            got.count      = m_axis_tdata[120:114];
            got.pad        = m_axis_tdata[127:121];
            got.last       = m_axis_tlast;
            sb.check_reply(got);
        end
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_NONE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unused action, extremes, duplicate indexes, tail moves.
        send_item(ACT_REBUILD, '0, '0, '0);
        send_item(ACT_NONE, '1, '1, '1);
        send_item(ACT_REMOVE, 24'h000005, '0, '0);
        send_item(ACT_ADD, '0, '0, '0);
        send_item(ACT_ADD, '1, '1, '1);
        send_item(ACT_ADD, 24'h000123, 32'h0001_0000, 16'h0100);
        send_item(ACT_ADD, 24'h000123, 32'h0000_8000, 16'h0080);
        send_item(ACT_REBUILD, '0, '0, '0);
        send_item(ACT_REMOVE, 24'h000123, '0, '0);
        send_item(ACT_REMOVE, 24'h0ABCDE, '1, '1);
        send_item(ACT_REBUILD, '1, '1, '1);
        send_item(ACT_NONE, 24'h5A5A5A, 32'hA5A5_A5A5, 16'h5A5A);
        send_item(ACT_REMOVE, '0, '0, '0);
        send_item(ACT_REMOVE, '1, '0, '0);
        send_item(ACT_REBUILD, '0, '0, '0);
        send_item(ACT_REMOVE, 24'h000123, '0, '0);
        send_item(ACT_REBUILD, '0, '0, '0);

        // Random churn, idling switched on and off in blocks.
        repeat (4)
        begin
            tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            rx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            repeat (20) churn_item();
        end

        // Fill with heavy sites to drive the total up, then overflow the table.
        tx_max_gap = 0;
        rx_max_gap = 0;
        while (sb.sites < TABLE_DEPTH)
        begin
            if ($urandom_range(3, 0) == 0)
                send_item(ACT_ADD, pick_site_id(), pick_rate(), pick_mult());
            else
                send_item(ACT_ADD, pick_site_id(), ~RATE_W'($urandom_range(255, 0)),
                          ~MULT_W'($urandom_range(15, 0)));
        end
        repeat (3) send_item(ACT_ADD, pick_site_id(), pick_rate(), pick_mult());
        send_item(ACT_REBUILD, '0, '0, '0);
        wait_drained();

        // Receiver stalls for a long stretch while the sender keeps offering.
        hold_off_req = 1'b1;
        repeat (12) send_item(ACT_REMOVE, existing_site_id(), '0, '0);
        send_item(ACT_REBUILD, '0, '0, '0);

        // Drain the table down to three sites, with a rebuild now and then.
        tx_max_gap = GAP_MAX;
        rx_max_gap = 0;
        while (sb.sites > 3)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(ACT_REBUILD, pick_site_id(), $urandom, MULT_W'($urandom));
            else
                remove_some_site();
        end

        tx_max_gap = 0;
        rx_max_gap = GAP_MAX;
        while (items_sent < ITEM_TARGET)
            churn_item();

        rx_max_gap = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- weighted_site_rate_table.f -----
sv/wsrt_pkg.sv
sv/wsrt_ram.sv
sv/wsrt_ctrl.sv
sv/wsrt_dp.sv
sv/weighted_site_rate_table.sv
verif/testbench.sv
